### hdl/sfcp_pkg.sv
// Shared types and constants for the sentence frame checksum parser.
// Depends on nothing; used by sfcp_hdr_match and the top level.
package sfcp_pkg;

    // Command codes, as reported in the result word
    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_ANGST = 3'd1,
        CMD_ANGRD = 3'd2,
        CMD_PIDST = 3'd3,
        CMD_PIDRD = 3'd4,
        CMD_ANCAL = 3'd5
    } cmd_t;

    localparam int HDR_LEN  = 6;
    localparam int TAIL_LEN = 5;
    localparam int NUM_CMDS = 5;

    // Header window: index 0 is the newest byte, index HDR_LEN-1 the oldest,
    // so a string literal compares directly.
    typedef logic [HDR_LEN-1:0][7:0]  hdr_win_t;
    // Tail of the open frame, same ordering (index 0 newest).
    typedef logic [TAIL_LEN-1:0][7:0] tail_t;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Command headers, table entry k maps to command code k+1
    localparam hdr_win_t HDR_TABLE [NUM_CMDS] = '{
        "$ANGST", "$ANGRD", "$PIDST", "$PIDRD", "$ANCAL"
    };

    // Output and input word widths (tdata)
    localparam int OUT_TDATA_W = 40;
    localparam int IN_TDATA_W  = 8;

    // Upper-case hex character for the low nibble of v
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] r;
        if (v >= 4'd10)
            r = 8'("A") + {4'd0, v} - 8'd10;
        else
            r = 8'("0") + {4'd0, v};
        return r;
    endfunction

endpackage

### hdl/sentence_frame_checksum_parser_unit.sv
// Top level of the sentence frame checksum parser: frame state and result register.
// Depends on sfcp_pkg and sfcp_hdr_match.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | s_tdata: rx_byte
//  m_*     | out | m_tvalid/m_tready  | m_tdata, m_tlast (frame_end), m_tuser
//
// One word in, one word out; a byte is taken every cycle while the result
// register is empty or being drained. m_tvalid rises in the cycle after
// accept, set by the single result register after the window compare and
// XOR update. A stall on m_tready holds the result and drops s_tready.
// Reset clears the frame state and the result valid flag at once.
module sentence_frame_checksum_parser_unit
    import sfcp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] data_byte, [15:8] position, [16] frame_good, [19:17] command,
    // [28:20] frame_length, [29] overflow, [37:30] checksum_value, [39:38] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast,   // frame_end
    output logic [0:0]             m_tuser    // [0] in_frame
);

    localparam logic [8:0] MAX_CNT = 9'(MAX_FRAME_LEN);
    localparam logic [8:0] HDR_CNT = 9'(HDR_LEN);

    // Frame state
    hdr_win_t   window_reg, window_next;
    logic       frame_open_reg, frame_open_next;
    cmd_t       cmd_reg, cmd_next;
    logic [8:0] count_reg, count_next;
    tail_t      tail_reg, tail_next;
    logic [7:0] xor_reg, xor_next;

    // Result register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic       out_in_frame_reg;
    logic [7:0] out_pos_reg;
    logic       out_end_reg;
    logic       out_good_reg;
    cmd_t       out_cmd_reg;
    logic [8:0] out_len_reg;
    logic       out_ovf_reg;
    logic [7:0] out_sum_reg;

    // Per-word results
    logic       r_in_frame;
    logic [7:0] r_pos;
    logic       r_end;
    logic       r_good;
    cmd_t       r_cmd;
    logic [8:0] r_len;
    logic       r_ovf;
    logic [7:0] r_sum;

    logic       accept;
    logic [7:0] rx_byte;
    logic [8:0] count_inc;
    logic       close_hit;
    cmd_t       match_cmd;

    assign rx_byte  = s_tdata[7:0];
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Window shifts on every accepted byte; a close or overflow clears it instead
    assign window_next = {window_reg[HDR_LEN-2:0], rx_byte};

    sfcp_hdr_match u_match (
        .window (window_next),
        .cmd    (match_cmd)
    );

    assign count_inc = count_reg + 9'd1;
    assign close_hit = (tail_reg[0] == CHAR_CR) && (rx_byte == CHAR_LF);

    // Next frame state and result fields for the current word
    always_comb
    begin
        frame_open_next = frame_open_reg;
        cmd_next        = cmd_reg;
        count_next      = count_reg;
        tail_next       = tail_reg;
        xor_next        = xor_reg;

        r_in_frame = 1'b0;
        r_pos      = 8'd0;
        r_end      = 1'b0;
        r_good     = 1'b0;
        r_cmd      = CMD_NONE;
        r_len      = 9'd0;
        r_ovf      = 1'b0;
        r_sum      = 8'd0;

        if (frame_open_reg)
        begin
            xor_next   = xor_reg ^ tail_reg[TAIL_LEN-1];
            tail_next  = {tail_reg[TAIL_LEN-2:0], rx_byte};
            count_next = count_inc;
            r_in_frame = 1'b1;
            r_pos      = count_reg[7:0];
            r_cmd      = cmd_reg;

            if (close_hit)
            begin
                // hex digits sit two bytes and one byte before CR
                r_end  = 1'b1;
                r_good = (hex_char(xor_next[7:4]) == tail_reg[2]) &&
                         (hex_char(xor_next[3:0]) == tail_reg[1]);
                r_len  = count_inc;
                r_sum  = xor_next;
            end
            else if (count_inc >= MAX_CNT)
            begin
                r_ovf = 1'b1;
            end
        end
        else if (match_cmd != CMD_NONE)
        begin
            frame_open_next = 1'b1;
            cmd_next        = match_cmd;
            count_next      = HDR_CNT;
            tail_next       = window_next[TAIL_LEN-1:0];
            xor_next        = 8'd0;
            r_in_frame      = 1'b1;
            r_pos           = 8'(HDR_LEN - 1);
            r_cmd           = match_cmd;
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !m_tready);

    // Frame state registers; a close or overflow clears all frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            frame_open_reg <= 1'b0;
            cmd_reg        <= CMD_NONE;
            count_reg      <= '0;
            tail_reg       <= '0;
            xor_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                if (r_end || r_ovf)
                begin
                    window_reg     <= '0;
                    frame_open_reg <= 1'b0;
                    cmd_reg        <= CMD_NONE;
                    count_reg      <= '0;
                    tail_reg       <= '0;
                    xor_reg        <= '0;
                end
                else
                begin
                    window_reg     <= window_next;
                    frame_open_reg <= frame_open_next;
                    cmd_reg        <= cmd_next;
                    count_reg      <= count_next;
                    tail_reg       <= tail_next;
                    xor_reg        <= xor_next;
                end
            end
        end
    end

    // Result payload, loaded on accept
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg     <= rx_byte;
            out_in_frame_reg <= r_in_frame;
            out_pos_reg      <= r_pos;
            out_end_reg      <= r_end;
            out_good_reg     <= r_good;
            out_cmd_reg      <= r_cmd;
            out_len_reg      <= r_len;
            out_ovf_reg      <= r_ovf;
            out_sum_reg      <= r_sum;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = out_in_frame_reg;
    assign m_tdata  = {2'b00, out_sum_reg, out_ovf_reg, out_len_reg, out_cmd_reg,
                       out_good_reg, out_pos_reg, out_data_reg};

`ifndef SYNTHESIS
    // An open frame always holds at least the header and stays below the limit
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> (count_reg >= HDR_CNT) && (count_reg < MAX_CNT))
        else $error("frame byte count out of range");

    // Idle parser carries no leftover count, checksum or command
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> (count_reg == 9'd0) && (xor_reg == 8'd0) && (cmd_reg == CMD_NONE))
        else $error("idle parser holds stale frame state");

    // A closing or dropping word leaves the parser idle
    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (r_end || r_ovf) |=> !frame_open_reg)
        else $error("frame still open after close or overflow");

    // End and overflow are exclusive and both belong to a frame
    a_end_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_end_reg || out_ovf_reg) |->
            !(out_end_reg && out_ovf_reg) && out_in_frame_reg && (out_cmd_reg != CMD_NONE))
        else $error("inconsistent frame end flags");
`endif

endmodule

### hdl/sfcp_hdr_match.sv
// Header decoder: compares the six-byte window against the command headers.
// Depends on sfcp_pkg for the header table and command codes.
module sfcp_hdr_match
    import sfcp_pkg::*;
(
    input  hdr_win_t window,
    output cmd_t     cmd
);

    // First matching header wins; walk backward so the lowest entry is last
    always_comb
    begin
        cmd = CMD_NONE;
        for (int k = NUM_CMDS - 1; k >= 0; k--)
        begin
            if (window == HDR_TABLE[k])
                cmd = cmd_t'(3'(k + 1));
        end
    end

endmodule

### tb/tb_sentence_frame_checksum_parser_unit.sv
// Testbench for sentence_frame_checksum_parser_unit: byte stream in, one result word per byte out.
// A built-in predictor of the frame parser checks every result word.
// Depends on sfcp_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_sentence_frame_checksum_parser_unit;
    import sfcp_pkg::*;

    localparam int FRAME_LIMIT = 256;
    localparam int HOLD_CYCLES = 120;
    localparam int IDLE_LIMIT  = 2000;
    localparam int DRAIN_WAIT  = 8;
    localparam int RANDOM_BYTES = 100;

    // Command headers, first character in the top byte; entry k is command k+1
    localparam logic [47:0] CMD_HEADERS [5] = '{
        "$ANGST", "$ANGRD", "$PIDST", "$PIDRD", "$ANCAL"
    };

    // Shapes of generated sentences
    typedef enum {
        FRM_GOOD,
        FRM_BAD_SUM,
        FRM_LOWER_HEX,
        FRM_EARLY_END,
        FRM_NO_TAIL
    } frame_kind_t;

    // Fields of one result word
    typedef struct packed {
        logic [7:0] data_byte;
        logic       in_frame;
        logic [7:0] position;
        logic       frame_end;
        logic       frame_good;
        cmd_t       command;
        logic [8:0] frame_length;
        logic       overflow;
        logic [7:0] checksum_value;
    } parse_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;
    logic [0:0]             m_tuser;

    // Predictor state
    logic [47:0] hdr_window;      // newest byte in [7:0]
    logic        frm_open;
    cmd_t        frm_cmd;
    logic [8:0]  frm_count;
    logic [7:0]  frm_tail [5];    // index 0 oldest
    logic [7:0]  frm_xor;

    parse_result_t pending_results [$];
    int          err_count   = 0;
    int          words_seen  = 0;
    int          bytes_sent  = 0;
    int          idle_cycles = 0;
    bit          src_gaps_on = 1'b1;
    bit          snk_gaps_on = 1'b1;
    bit          snk_hold_req = 1'b0;

    sentence_frame_checksum_parser_unit #(
        .MAX_FRAME_LEN(FRAME_LIMIT)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Upper-case hex character of a nibble
    function automatic logic [7:0] hex_ascii(input logic [3:0] n);
        if (n >= 4'd10)
            return 8'h41 + 8'(n - 4'd10);
        return 8'h30 + 8'(n);
    endfunction

    function automatic void clear_parser_state();
        int i;
        hdr_window = '0;
        frm_open   = 1'b0;
        frm_cmd    = CMD_NONE;
        frm_count  = '0;
        frm_xor    = '0;
        for (i = 0; i < 5; i++)
            frm_tail[i] = 8'h00;
    endfunction

    // Expected result of one received byte; advances the parser state
    function automatic parse_result_t parse_rx_byte(input logic [7:0] b);
        parse_result_t r;
        bit            hit;
        int            i;
        int            k;
        r = '0;
        hit = 1'b0;
        r.data_byte = b;
        hdr_window = {hdr_window[39:0], b};
        if (frm_open) begin
            r.in_frame = 1'b1;
            r.position = frm_count[7:0];
            r.command  = frm_cmd;
            frm_xor = frm_xor ^ frm_tail[0];
            for (i = 0; i < 4; i++)
                frm_tail[i] = frm_tail[i + 1];
            frm_tail[4] = b;
            frm_count = frm_count + 9'd1;
            if (frm_tail[3] == CHAR_CR && frm_tail[4] == CHAR_LF) begin
                r.frame_end      = 1'b1;
                r.frame_good     = (hex_ascii(frm_xor[7:4]) == frm_tail[1]) &&
                                   (hex_ascii(frm_xor[3:0]) == frm_tail[2]);
                r.frame_length   = frm_count;
                r.checksum_value = frm_xor;
                clear_parser_state();
            end else if (frm_count >= FRAME_LIMIT) begin
                r.overflow = 1'b1;
                clear_parser_state();
            end
        end else begin
            for (k = 0; k < 5; k++) begin
                if (!hit && hdr_window == CMD_HEADERS[k]) begin
                    hit       = 1'b1;
                    frm_open  = 1'b1;
                    frm_cmd   = cmd_t'(k + 1);
                    frm_count = 9'd6;
                    frm_xor   = 8'h00;
                    // tail takes the five newest header bytes
                    for (i = 0; i < 5; i++)
                        frm_tail[i] = hdr_window[39 - 8 * i -: 8];
                    r.in_frame = 1'b1;
                    r.position = 8'd5;
                    r.command  = frm_cmd;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] expv,
                                   input logic [15:0] gotv);
        err_count++;
        if (err_count <= 40)
            $display("ERROR word %0d %s: expected 0x%0h got 0x%0h",
                     words_seen, what, expv, gotv);
    endtask

    task automatic check_field(input string what, input logic [15:0] expv,
                               input logic [15:0] gotv);
        if (expv !== gotv)
            report_mismatch(what, expv, gotv);
    endtask

    // Offer one byte after a random gap when source gaps are on; predict its result once accepted
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_gaps_on ? $urandom_range(7) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(parse_rx_byte(b));
        bytes_sent++;
    endtask

    task automatic send_text(input string txt);
        int j;
        for (j = 0; j < txt.len(); j++)
            send_byte(txt[j]);
    endtask

    // Stop offering and wait for every outstanding result word
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // One sentence: header, body, '*', two hex characters, CR LF; FRM_NO_TAIL stops after the body
    task automatic send_frame(input int cmd_idx, input int body_len,
                              input frame_kind_t kind, input bit full_range_body);
        logic [7:0] sum;
        logic [7:0] c;
        logic [7:0] hi;
        logic [7:0] lo;
        int         j;
        sum = 8'h00;
        for (j = 0; j < 6; j++) begin
            c = CMD_HEADERS[cmd_idx][47 - 8 * j -: 8];
            if (j > 0)
                sum ^= c;
            send_byte(c);
        end
        for (j = 0; j < body_len; j++) begin
            // stray CR LF in mid body closes the sentence early
            if (kind == FRM_EARLY_END && j == body_len / 2) begin
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            c = full_range_body ? 8'($urandom_range(255)) : 8'($urandom_range(126, 32));
            sum ^= c;
            send_byte(c);
        end
        if (kind == FRM_NO_TAIL)
            return;
        hi = hex_ascii(sum[7:4]);
        lo = hex_ascii(sum[3:0]);
        if (kind == FRM_BAD_SUM)
            lo = hex_ascii(sum[3:0] ^ 4'($urandom_range(15, 1)));
        if (kind == FRM_LOWER_HEX) begin
            if (hi >= 8'h41)
                hi = hi | 8'h20;
            if (lo >= 8'h41)
                lo = lo | 8'h20;
        end
        send_byte("*");
        send_byte(hi);
        send_byte(lo);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    // Line noise, shortest frame, near-miss header
    task automatic test_idle_line_and_short_frame();
        send_text("$AN");
        send_text("$ANGRD");
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        send_text("$ANGSt");
    endtask

    // Good and bad sentence for every command
    task automatic test_each_command();
        int k;
        for (k = 0; k < 5; k++) begin
            send_frame(k, $urandom_range(4), FRM_GOOD, 1'b0);
            send_frame(k, $urandom_range(4, 1), FRM_BAD_SUM, 1'b0);
        end
    endtask

    // Longest legal sentence and one that runs past the limit
    task automatic test_max_length_and_overflow();
        send_frame($urandom_range(4), FRAME_LIMIT - 11, FRM_GOOD, 1'b0);
        send_frame($urandom_range(4), FRAME_LIMIT - 6, FRM_NO_TAIL, 1'b0);
    endtask

    // Receiver holds off while the sender keeps offering, then sender pauses
    task automatic test_backpressure();
        int k;
        src_gaps_on  = 1'b0;
        snk_hold_req = 1'b1;
        for (k = 0; k < 3; k++)
            send_frame(k, $urandom_range(6), FRM_GOOD, 1'b0);
        wait_drained();
        src_gaps_on = 1'b1;
        send_frame(4, 3, FRM_GOOD, 1'b0);
    endtask

    // Mostly well-formed sentences with random content, plus noise and broken ones
    task automatic test_random_traffic();
        int          start_count;
        int          pick;
        int          n;
        int          j;
        int          k;
        int          p;
        int          blen;
        frame_kind_t kind;
        start_count = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            if ($urandom_range(5) == 0)
                src_gaps_on = !src_gaps_on;
            if ($urandom_range(5) == 0)
                snk_gaps_on = !snk_gaps_on;
            pick = $urandom_range(99);
            if (pick < 78) begin
                n = $urandom_range(99);
                if (n < 60)
                    kind = FRM_GOOD;
                else if (n < 75)
                    kind = FRM_BAD_SUM;
                else if (n < 85)
                    kind = FRM_LOWER_HEX;
                else if (n < 94)
                    kind = FRM_EARLY_END;
                else
                    kind = FRM_NO_TAIL;
                blen = $urandom_range(12);
                if (kind == FRM_EARLY_END && blen < 2)
                    blen = 2;
                send_frame($urandom_range(4), blen, kind, $urandom_range(9) == 0);
            end else begin
                // noise burst, sometimes a partial header
                n = $urandom_range(6, 1);
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(3) == 0) begin
                        k = $urandom_range(4);
                        p = $urandom_range(5, 1);
                        for (int q = 0; q < p; q++)
                            send_byte(CMD_HEADERS[k][47 - 8 * q -: 8]);
                    end else begin
                        send_byte(8'($urandom_range(255)));
                    end
                end
            end
        end
        src_gaps_on = 1'b1;
        snk_gaps_on = 1'b1;
    endtask

    // Result side: random stalls, one long hold-off on request, check each word
    initial begin : result_sink
        int            stall;
        parse_result_t exp_r;
        m_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever begin
            if (snk_hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                snk_hold_req = 1'b0;
            end
            stall = snk_gaps_on ? $urandom_range(7) : 0;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            words_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected word, data_byte", 16'h0, m_tdata[7:0]);
            end else begin
                exp_r = pending_results.pop_front();
                check_field("data_byte", exp_r.data_byte, m_tdata[7:0]);
                check_field("in_frame", exp_r.in_frame, m_tuser[0]);
                check_field("position", exp_r.position, m_tdata[15:8]);
                check_field("frame_end", exp_r.frame_end, m_tlast);
                check_field("frame_good", exp_r.frame_good, m_tdata[16]);
                check_field("command", exp_r.command, m_tdata[19:17]);
                check_field("frame_length", exp_r.frame_length, m_tdata[28:20]);
                check_field("overflow", exp_r.overflow, m_tdata[29]);
                check_field("checksum_value", exp_r.checksum_value, m_tdata[37:30]);
                check_field("pad bits", 16'h0, m_tdata[39:38]);
            end
        end
    end

    // Watchdog: cycles without any word moving on either side
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_sentence_frame_checksum_parser_unit NOT OK");
                $finish;
            end
        end
    end

    // Test sequence
    initial begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        clear_parser_state();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_line_and_short_frame();
        test_each_command();
        test_max_length_and_overflow();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (err_count == 0)
            $display("tb_sentence_frame_checksum_parser_unit OK");
        else
            $display("tb_sentence_frame_checksum_parser_unit NOT OK");
        $finish;
    end

endmodule

### sentence_frame_checksum_parser_unit.f
hdl/sfcp_pkg.sv
hdl/sfcp_hdr_match.sv
hdl/sentence_frame_checksum_parser_unit.sv
tb/tb_sentence_frame_checksum_parser_unit.sv
